// ===== rtl/core/stg_pkg.sv =====
package stg_pkg;

  localparam int SINE_ENTRIES = 1024;
  localparam int NOTE_COUNT   = 8;

  localparam int IDX_W  = $clog2(SINE_ENTRIES);
  localparam int NOTE_W = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam int PH_W   = 16;
  localparam int DQ_W   = PH_W + IDX_W;
  localparam int FREQ_W = 11;
  localparam int CNT_W  = 5;
  localparam int AMP_W  = 15;
  localparam int CFG_W  = 16;
  localparam int UPC_W  = 4;

  localparam logic [0:0] REG_SAMPLE_RATE = 1'd0;
  localparam logic [0:0] REG_AMPLITUDE   = 1'd1;

  localparam logic [PH_W-1:0]  SAMPLE_RATE_RST = 16'd44100;
  localparam logic [AMP_W-1:0] AMPLITUDE_RST   = 15'd10000;

  // loop counts, loaded as count minus one
  localparam logic [CNT_W-1:0] CNT_MOD_PH  = CNT_W'(PH_W - 1);
  localparam logic [CNT_W-1:0] CNT_MOD_SUM = CNT_W'(PH_W);
  localparam logic [CNT_W-1:0] CNT_IDX     = CNT_W'(IDX_W - 1);

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD_PH,
    OP_DIV,
    OP_SAVE_PH,
    OP_MUL_IDX,
    OP_LOAD_IDX,
    OP_ROM,
    OP_SCALE,
    OP_EMIT,
    OP_SAVE_PC
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_TICK,
    C_PH_READY,
    C_CNT_NZ,
    C_PHASE_DONE
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    op_t  op;
    logic en;
    logic fire;
    logic restart;
  } ctrl_t;

  typedef struct packed {
    logic ph_ready;
    logic cnt_nz;
    logic phase_done;
    logic out_busy;
  } stat_t;

  localparam logic [UPC_W-1:0] U_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] U_LDPC   = 4'd1;
  localparam logic [UPC_W-1:0] U_MODPC  = 4'd2;
  localparam logic [UPC_W-1:0] U_SVPH   = 4'd3;
  localparam logic [UPC_W-1:0] U_MUL    = 4'd4;
  localparam logic [UPC_W-1:0] U_LDIX   = 4'd5;
  localparam logic [UPC_W-1:0] U_DIVIX  = 4'd6;
  localparam logic [UPC_W-1:0] U_ROM    = 4'd7;
  localparam logic [UPC_W-1:0] U_SCALE  = 4'd8;
  localparam logic [UPC_W-1:0] U_EMIT   = 4'd9;
  localparam logic [UPC_W-1:0] U_MODSUM = 4'd10;
  localparam logic [UPC_W-1:0] U_SVPC   = 4'd11;

  function automatic ucw_t ucode(input logic [UPC_W-1:0] addr);
    ucw_t w;
    unique case (addr)
      U_IDLE:   w = '{OP_IDLE,     C_NO_TICK,    U_IDLE};
      U_LDPC:   w = '{OP_LOAD_PH,  C_PH_READY,   U_MUL};
      U_MODPC:  w = '{OP_DIV,      C_CNT_NZ,     U_MODPC};
      U_SVPH:   w = '{OP_SAVE_PH,  C_NEVER,      U_IDLE};
      U_MUL:    w = '{OP_MUL_IDX,  C_NEVER,      U_IDLE};
      U_LDIX:   w = '{OP_LOAD_IDX, C_NEVER,      U_IDLE};
      U_DIVIX:  w = '{OP_DIV,      C_CNT_NZ,     U_DIVIX};
      U_ROM:    w = '{OP_ROM,      C_NEVER,      U_IDLE};
      U_SCALE:  w = '{OP_SCALE,    C_NEVER,      U_IDLE};
      U_EMIT:   w = '{OP_EMIT,     C_PHASE_DONE, U_IDLE};
      U_MODSUM: w = '{OP_DIV,      C_CNT_NZ,     U_MODSUM};
      U_SVPC:   w = '{OP_SAVE_PC,  C_ALWAYS,     U_IDLE};
      default:  w = '{OP_IDLE,     C_ALWAYS,     U_IDLE};
    endcase
    return w;
  endfunction

  // C major from C4, continuing upward past C5
  function automatic logic [FREQ_W-1:0] note_freq(input logic [3:0] n);
    logic [FREQ_W-1:0] f;
    unique case (n)
      4'd0:  f = 11'd261;
      4'd1:  f = 11'd294;
      4'd2:  f = 11'd330;
      4'd3:  f = 11'd349;
      4'd4:  f = 11'd392;
      4'd5:  f = 11'd440;
      4'd6:  f = 11'd494;
      4'd7:  f = 11'd523;
      4'd8:  f = 11'd587;
      4'd9:  f = 11'd659;
      4'd10: f = 11'd698;
      4'd11: f = 11'd784;
      4'd12: f = 11'd880;
      4'd13: f = 11'd988;
      4'd14: f = 11'd1047;
      default: f = 11'd1175;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/stg_if.sv =====
interface stg_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface stg_tone_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [2:0]         note_index;
  logic               last;

  modport source (output valid, output sample, output note_index, output last, input ready);
  modport sink   (input valid, input sample, input note_index, input last, output ready);
endinterface

// ===== rtl/core/stg_sine_rom.sv =====
module stg_sine_rom (
  input  logic                      clk,
  input  logic                      en,
  input  logic [stg_pkg::IDX_W-1:0] addr,
  output logic signed [15:0]        data
);
  import stg_pkg::*;

  typedef logic signed [15:0] sine_tab_t [SINE_ENTRIES];

  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned TWO_PI_Q30  = 2 * PI_Q30;
  localparam longint unsigned DIVS [6]    = '{156, 110, 72, 42, 20, 6};

  // Q1.15 sine by a folded Horner series, Q30 internally
  function automatic sine_tab_t build_sine();
    sine_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned p;
    longint unsigned s;
    longint unsigned e;
    logic            neg;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      x   = (longint'(k) * TWO_PI_Q30) / SINE_ENTRIES;
      neg = 1'b0;
      if (x >= PI_Q30) begin
        x   = x - PI_Q30;
        neg = 1'b1;
      end
      if (x > HALF_PI_Q30) x = PI_Q30 - x;
      x2 = (x * x) >> 30;
      t  = ONE_Q30;
      for (int i = 0; i < 6; i++) begin
        p = ((x2 * t) >> 30) / DIVS[i];
        t = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
      end
      s = (x * t) >> 30;
      e = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (e > 64'd32767) e = 64'd32767;
      tab[k] = neg ? -16'(e) : 16'(e);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  always_ff @(posedge clk) begin
    if (en) data <= SINE_TAB[addr];
  end

endmodule

// ===== rtl/core/stg_datapath.sv =====
module stg_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [0:0]                cfg_index,
  input  logic [stg_pkg::CFG_W-1:0] cfg_data,
  input  stg_pkg::ctrl_t            ctrl,
  output stg_pkg::stat_t            stat,
  stg_tone_if.source                tone
);
  import stg_pkg::*;

  logic [PH_W-1:0]   sample_rate;
  logic [AMP_W-1:0]  amplitude;
  logic [PH_W-1:0]   phase_count;
  logic [PH_W-1:0]   sample_in_note;
  logic [NOTE_W-1:0] note_number;
  logic              out_valid;

  logic [PH_W-1:0]        ph;
  logic [PH_W-1:0]        rem;
  logic [DQ_W-1:0]        dq;
  logic [CNT_W-1:0]       cnt;
  logic [2*AMP_W-1:0]     prod;
  logic                   sgn;
  logic signed [15:0]     rom_data;
  logic signed [15:0]     sample;
  logic [2:0]             note_index;
  logic                   last;

  logic [PH_W-1:0]   rate;
  logic [PH_W:0]     rem_sh;
  logic [PH_W:0]     rem_sub;
  logic              ge;
  logic [PH_W:0]     sum;
  logic              note_end;
  logic              sum_lt;
  logic              final_note;
  logic [NOTE_W-1:0] note_wrap;
  logic [3:0]        note4;
  logic [15:0]       rom_abs;
  logic [AMP_W-1:0]  mag;

  assign rate       = (sample_rate == '0) ? PH_W'(1) : sample_rate;
  assign rem_sh     = {rem, dq[DQ_W-1]};
  assign rem_sub    = rem_sh - {1'b0, rate};
  assign ge         = rem_sh >= {1'b0, rate};
  assign note4      = 4'(note_number);
  assign sum        = {1'b0, ph} + (PH_W+1)'(note_freq(note4));
  assign note_end   = ({1'b0, sample_in_note} + 17'd1) >= {1'b0, rate};
  assign sum_lt     = sum < {1'b0, rate};
  assign final_note = note_number == NOTE_W'(NOTE_COUNT - 1);
  assign note_wrap  = final_note ? '0 : note_number + NOTE_W'(1);
  assign rom_abs    = rom_data[15] ? 16'(-rom_data) : rom_data;
  assign mag        = prod[2*AMP_W-1:AMP_W];

  assign stat.ph_ready   = phase_count < rate;
  assign stat.cnt_nz     = cnt != '0;
  assign stat.phase_done = note_end || sum_lt;
  assign stat.out_busy   = out_valid && !tone.ready;

  assign tone.valid      = out_valid;
  assign tone.sample     = sample;
  assign tone.note_index = note_index;
  assign tone.last       = last;

  stg_sine_rom u_rom (
    .clk  (clk),
    .en   (ctrl.en && ctrl.op == OP_ROM),
    .addr (dq[IDX_W-1:0]),
    .data (rom_data)
  );

  // configuration, note state and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate    <= SAMPLE_RATE_RST;
      amplitude      <= AMPLITUDE_RST;
      phase_count    <= '0;
      sample_in_note <= '0;
      note_number    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SAMPLE_RATE: sample_rate <= cfg_data;
          REG_AMPLITUDE:   amplitude   <= cfg_data[AMP_W-1:0];
          default: ;
        endcase
      end
      // a new beat loaded in the same cycle keeps valid high
      if (out_valid && tone.ready && !(ctrl.en && ctrl.op == OP_EMIT)) out_valid <= 1'b0;
      if (ctrl.en) begin
        unique case (ctrl.op)
          OP_IDLE: begin
            if (ctrl.fire && ctrl.restart) begin
              phase_count    <= '0;
              sample_in_note <= '0;
              note_number    <= '0;
            end
          end
          OP_EMIT: begin
            out_valid <= 1'b1;
            if (note_end) begin
              sample_in_note <= '0;
              phase_count    <= '0;
              note_number    <= note_wrap;
            end else begin
              sample_in_note <= sample_in_note + PH_W'(1);
              if (sum_lt) phase_count <= sum[PH_W-1:0];
            end
          end
          OP_SAVE_PC: phase_count <= rem;
          default: ;
        endcase
      end
    end
  end

  // shared shift-subtract divider, multipliers and result payload
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      unique case (ctrl.op)
        OP_LOAD_PH: begin
          ph  <= phase_count;
          rem <= '0;
          dq  <= {phase_count, {IDX_W{1'b0}}};
          cnt <= CNT_MOD_PH;
        end
        OP_DIV: begin
          rem <= ge ? rem_sub[PH_W-1:0] : rem_sh[PH_W-1:0];
          dq  <= {dq[DQ_W-2:0], ge};
          cnt <= cnt - CNT_W'(1);
        end
        OP_SAVE_PH:  ph <= rem;
        OP_MUL_IDX:  dq <= {{IDX_W{1'b0}}, ph} * DQ_W'(SINE_ENTRIES);
        OP_LOAD_IDX: begin
          // top bits of ph*N stay below the rate, so they seed the remainder
          rem <= dq[DQ_W-1:IDX_W];
          dq  <= {dq[IDX_W-1:0], {PH_W{1'b0}}};
          cnt <= CNT_IDX;
        end
        OP_SCALE: begin
          prod <= amplitude * rom_abs[AMP_W-1:0];
          sgn  <= rom_data[15];
        end
        OP_EMIT: begin
          sample     <= sgn ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
          // the final beat of a note already reports the following note
          note_index <= 3'(note_end ? note_wrap : note_number);
          last       <= note_end && final_note;
          rem        <= '0;
          dq         <= {sum, {(IDX_W-1){1'b0}}};
          cnt        <= CNT_MOD_SUM;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/stg_useq.sv =====
module stg_useq (
  input  logic           clk,
  input  logic           rst,
  input  stg_pkg::stat_t stat,
  output stg_pkg::ctrl_t ctrl,
  stg_tick_if.sink       tick
);
  import stg_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  ucw_t             cw;
  logic             take;
  logic             stall;

  assign cw         = ucode(upc);
  assign tick.ready = upc == U_IDLE;
  assign stall      = cw.op == OP_EMIT && stat.out_busy;

  assign ctrl.op      = cw.op;
  assign ctrl.en      = !stall;
  assign ctrl.fire    = tick.valid && tick.ready;
  assign ctrl.restart = tick.restart;

  always_comb begin
    unique case (cw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_NO_TICK:    take = !tick.valid;
      C_PH_READY:   take = stat.ph_ready;
      C_CNT_NZ:     take = stat.cnt_nz;
      C_PHASE_DONE: take = stat.phase_done;
      default:      take = 1'b1;
    endcase
    if (stall)     upc_next = upc;
    else if (take) upc_next = cw.target;
    else           upc_next = upc + UPC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) upc <= U_IDLE;
    else     upc <= upc_next;
  end

endmodule

// ===== rtl/core/scale_tone_generator.sv =====
// A tick beat is taken only in idle. A lowered sample rate that leaves the phase out
// of range adds a phase reduction before the result beat. A phase step that passes the
// rate adds a phase wrap divide before the next tick is taken. All divides share the
// single shift-subtract divider; a tick waits until the one before it is emitted.
// A result left waiting stalls the emit step and so the next tick.
// Reset (rst, synchronous): sample_rate 44100, amplitude 10000, first note, phase zero.
module scale_tone_generator (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [0:0]                cfg_index,
  input  logic [stg_pkg::CFG_W-1:0] cfg_data,
  stg_tick_if.sink                  tick,
  stg_tone_if.source                tone
);
  import stg_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  stg_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl),
    .tick (tick)
  );

  stg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .stat      (stat),
    .tone      (tone)
  );

`ifndef SYNTH
  // a tick beat moves the sequencer off idle
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> !tick.ready)
    else $error("sequencer stayed idle after tick beat");

  // a stalled emit step holds until the output register frees
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_EMIT && stat.out_busy |=> ctrl.op == OP_EMIT)
    else $error("emit step left while output busy");

  // an emit step that is not stalled always presents a result beat
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_EMIT && ctrl.en |=> tone.valid)
    else $error("emit step gave no result beat");
`endif

endmodule
